// ----- hdl/kct_pkg.sv -----
// Package for the keyed count table: entry layout, operation codes and
// the control word that the top level hands to the table store.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kct_pkg;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 16;
  localparam int MODE_W  = 4;
  localparam int SLOT_W  = 8;
  localparam int USED_W  = 9;
  localparam int IN_W    = 88;
  localparam int OUT_W   = 64;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 4'd0;
  localparam logic [MODE_W-1:0] MODE_INC    = 4'd1;
  localparam logic [MODE_W-1:0] MODE_DEC    = 4'd2;
  localparam logic [MODE_W-1:0] MODE_SETKEY = 4'd3;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 4'd4;
  localparam logic [MODE_W-1:0] MODE_READ   = 4'd5;
  localparam logic [MODE_W-1:0] MODE_SETIDX = 4'd6;
  localparam logic [MODE_W-1:0] MODE_SWAP   = 4'd7;
  localparam logic [MODE_W-1:0] MODE_DEL    = 4'd8;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
  } entry_t;

  // store commands from the sequencer
  typedef struct packed {
    logic wr_en;     // write one entry
    logic clr_all;   // empty the whole table
    logic clr_tail;  // empty every masked entry from clr_from upward
  } store_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/kct_store.sv -----
// Table store for the keyed count table: one synchronous memory of
// entries with one write and one registered read port, plus valid bits.
// Depends on kct_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kct_store #(
  parameter int ENTRIES = 32,
  localparam int AW = $clog2(ENTRIES)
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  kct_pkg::store_ctl_t  ctl,
  input  wire [AW-1:0]         wr_addr,
  input  kct_pkg::entry_t      wr_data,
  input  wire [AW:0]           clr_from,
  input  wire [ENTRIES-1:0]    clr_mask,
  input  wire [AW-1:0]         rd_addr,
  output kct_pkg::entry_t      rd_data
);

  kct_pkg::entry_t mem [ENTRIES];
  kct_pkg::entry_t mem_q_r;
  logic            occ_q_r;
  logic [ENTRIES-1:0] occ_r, occ_nxt;

  // invalid entries read as empty
  assign rd_data = occ_q_r ? mem_q_r : '0;

  always_comb begin
    occ_nxt = occ_r;
    if (ctl.clr_all) begin
      occ_nxt = '0;
    end
    if (ctl.clr_tail) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if ((AW+1)'(i) >= clr_from && clr_mask[i]) begin
          occ_nxt[i] = 1'b0;
        end
      end
    end
    if (ctl.wr_en) begin
      occ_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q_r <= mem[rd_addr];
    occ_q_r <= occ_r[rd_addr];
  end

endmodule
`default_nettype wire

// ----- hdl/keyed_count_table_unit.sv -----
// Keyed count table, top level: operation sequencer, result register
// and the table store instance. Depends on kct_pkg and kct_store.
//
// The block keeps ENTRIES slots of key and count in one synchronous
// memory (one write, one registered read per cycle) and executes one
// operation per transfer, returning one result transfer. Key operations
// (increment, decrement, set by key, lookup) scan the whole table one slot
// a cycle and then act on what they found; a decrement that removes its
// key adds a compaction pass over the table. Read and set by index work
// on one slot, swap reads and writes two slots, delete by index shifts
// the later slots down (one shifted slot a cycle), and clear or a rejected
// operation goes straight to the result. A new item is taken while the
// previous result still waits in the output register. Reset empties the
// table at once through per-slot valid bits; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module keyed_count_table_unit #(
  parameter int ENTRIES = 32
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  // mode[3:0], key[35:4], count_value[51:36], zero_default[67:52],
  // add_if_absent[68], remove_if_empty[69], slot_a[77:70], slot_b[85:78]
  input  wire [87:0] in_tdata,
  output logic       out_tvalid,
  input  wire        out_tready,
  // ok[0], key_out[32:1], count_out[48:33], keys_in_use[57:49]
  output logic [63:0] out_tdata
);

  localparam int AW = $clog2(ENTRIES);
  localparam int UW = $clog2(ENTRIES + 1);
  localparam logic [AW:0] N_CNT = (AW+1)'(ENTRIES);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_SCAN     = 12'b000000000010,
    S_APPLY    = 12'b000000000100,
    S_COMPACT  = 12'b000000001000,
    S_CTAIL    = 12'b000000010000,
    S_RD_A     = 12'b000000100000,
    S_GOT_A    = 12'b000001000000,
    S_SWAP_B   = 12'b000010000000,
    S_SWAP_W   = 12'b000100000000,
    S_SHIFT    = 12'b001000000000,
    S_DEL_LAST = 12'b010000000000,
    S_RESP     = 12'b100000000000
  } state_t;

  // input fields
  logic [kct_pkg::MODE_W-1:0]  in_mode;
  logic [kct_pkg::KEY_W-1:0]   in_key;
  logic [kct_pkg::COUNT_W-1:0] in_cval, in_zdef;
  logic                        in_add, in_rem;
  logic [kct_pkg::SLOT_W-1:0]  in_sa, in_sb;
  logic                        in_xfer, sa_ok, sb_ok;

  assign in_mode = in_tdata[3:0];
  assign in_key  = in_tdata[35:4];
  assign in_cval = in_tdata[51:36];
  assign in_zdef = in_tdata[67:52];
  assign in_add  = in_tdata[68];
  assign in_rem  = in_tdata[69];
  assign in_sa   = in_tdata[77:70];
  assign in_sb   = in_tdata[85:78];
  assign in_xfer = in_tvalid && in_tready;
  assign sa_ok   = {1'b0, in_sa} < 9'(ENTRIES);
  assign sb_ok   = {1'b0, in_sb} < 9'(ENTRIES);

  state_t state_r, state_nxt;

  // held operation
  logic [kct_pkg::MODE_W-1:0]  mode_r, mode_nxt;
  logic [kct_pkg::KEY_W-1:0]   key_r, key_nxt;
  logic [kct_pkg::COUNT_W-1:0] cval_r, cval_nxt, zdef_r, zdef_nxt;
  logic                        add_r, add_nxt, rem_r, rem_nxt;
  logic [AW-1:0]               sa_r, sa_nxt, sb_r, sb_nxt;

  // sequencer working state
  logic [AW:0]      cnt_r, cnt_nxt, wr_r, wr_nxt;
  logic             pend_r, pend_nxt;
  logic             found_r, found_nxt, efound_r, efound_nxt;
  logic [AW-1:0]    fpos_r, fpos_nxt, epos_r, epos_nxt;
  logic [kct_pkg::COUNT_W-1:0] fcount_r, fcount_nxt;
  kct_pkg::entry_t  hold_r, hold_nxt;
  logic [UW-1:0]    used_r, used_nxt;
  // slots whose key was moved during compaction; only these get emptied
  logic [ENTRIES-1:0] moved_r, moved_nxt;

  // result
  logic                        res_ok_r, res_ok_nxt;
  logic [kct_pkg::KEY_W-1:0]   res_key_r, res_key_nxt;
  logic [kct_pkg::COUNT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [63:0]                 out_data_r, out_data_nxt;

  // store port
  kct_pkg::store_ctl_t ctl;
  logic [AW-1:0]       wr_addr, rd_addr;
  kct_pkg::entry_t     wr_data, rd_data;
  logic [AW:0]         clr_from;

  // helpers
  logic [AW:0] cnt_m1, cnt_m2;
  logic [kct_pkg::COUNT_W-1:0] dec_cnt;

  assign cnt_m1  = cnt_r - (AW+1)'(1);
  assign cnt_m2  = cnt_r - (AW+1)'(2);
  assign dec_cnt = (fcount_r != '0) ? fcount_r - 16'd1 : '0;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  kct_store #(.ENTRIES(ENTRIES)) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .clr_from (clr_from),
    .clr_mask (moved_r),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    key_nxt    = key_r;
    cval_nxt   = cval_r;
    zdef_nxt   = zdef_r;
    add_nxt    = add_r;
    rem_nxt    = rem_r;
    sa_nxt     = sa_r;
    sb_nxt     = sb_r;
    cnt_nxt    = cnt_r;
    wr_nxt     = wr_r;
    pend_nxt   = pend_r;
    found_nxt  = found_r;
    efound_nxt = efound_r;
    fpos_nxt   = fpos_r;
    epos_nxt   = epos_r;
    fcount_nxt = fcount_r;
    hold_nxt   = hold_r;
    used_nxt   = used_r;
    moved_nxt  = moved_r;
    res_ok_nxt  = res_ok_r;
    res_key_nxt = res_key_r;
    res_cnt_nxt = res_cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ctl      = '0;
    wr_addr  = '0;
    wr_data  = '0;
    rd_addr  = '0;
    clr_from = wr_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          mode_nxt    = in_mode;
          key_nxt     = in_key;
          cval_nxt    = in_cval;
          zdef_nxt    = in_zdef;
          add_nxt     = in_add;
          rem_nxt     = in_rem;
          sa_nxt      = in_sa[AW-1:0];
          sb_nxt      = in_sb[AW-1:0];
          cnt_nxt     = '0;
          wr_nxt      = '0;
          pend_nxt    = 1'b0;
          found_nxt   = 1'b0;
          efound_nxt  = 1'b0;
          res_ok_nxt  = 1'b0;
          res_key_nxt = '0;
          res_cnt_nxt = '0;
          state_nxt   = S_RESP;
          unique case (in_mode) inside
            kct_pkg::MODE_CLEAR: begin
              ctl.clr_all = 1'b1;
              used_nxt    = '0;
              res_ok_nxt  = 1'b1;
            end
            kct_pkg::MODE_INC, kct_pkg::MODE_DEC,
            kct_pkg::MODE_SETKEY, kct_pkg::MODE_LOOKUP: begin
              // reject a zero key
              if (in_key != '0) state_nxt = S_SCAN;
            end
            kct_pkg::MODE_READ, kct_pkg::MODE_SETIDX, kct_pkg::MODE_DEL: begin
              if (sa_ok) state_nxt = S_RD_A;
            end
            kct_pkg::MODE_SWAP: begin
              if (sa_ok && sb_ok) state_nxt = S_RD_A;
            end
            default: begin
            end
          endcase
        end
      end

      // read every slot; note first match and first empty slot
      S_SCAN: begin
        if (cnt_r < N_CNT) begin
          rd_addr  = cnt_r[AW-1:0];
          cnt_nxt  = cnt_r + (AW+1)'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (rd_data.key == key_r && !found_r) begin
            found_nxt  = 1'b1;
            fpos_nxt   = cnt_m1[AW-1:0];
            fcount_nxt = rd_data.count;
          end
          if (rd_data.key == '0 && !efound_r) begin
            efound_nxt = 1'b1;
            epos_nxt   = cnt_m1[AW-1:0];
          end
        end
        if (cnt_r == N_CNT) state_nxt = S_APPLY;
      end

      S_APPLY: begin
        state_nxt = S_RESP;
        case (mode_r)
          kct_pkg::MODE_INC: begin
            if (found_r) begin
              ctl.wr_en  = 1'b1;
              wr_addr    = fpos_r;
              wr_data    = '{key: key_r, count: (fcount_r == kct_pkg::COUNT_MAX) ?
                                                fcount_r : fcount_r + 16'd1};
              res_ok_nxt = 1'b1;
            end else if (!add_r) begin
              res_ok_nxt = 1'b1;
            end else if (efound_r) begin
              ctl.wr_en  = 1'b1;
              wr_addr    = epos_r;
              wr_data    = '{key: key_r, count: 16'd1};
              used_nxt   = used_r + UW'(1);
              res_ok_nxt = 1'b1;
            end
          end
          kct_pkg::MODE_DEC: begin
            if (found_r) begin
              res_ok_nxt = (fcount_r != '0);
              ctl.wr_en  = 1'b1;
              wr_addr    = fpos_r;
              if (dec_cnt == '0 && rem_r) begin
                // empty the slot, then compact
                wr_data   = '0;
                used_nxt  = used_r - UW'(1);
                cnt_nxt   = '0;
                wr_nxt    = '0;
                pend_nxt  = 1'b0;
                moved_nxt = '0;
                state_nxt = S_COMPACT;
              end else begin
                wr_data = '{key: key_r, count: dec_cnt};
              end
            end
          end
          kct_pkg::MODE_SETKEY: begin
            if (found_r) begin
              ctl.wr_en  = 1'b1;
              wr_addr    = fpos_r;
              wr_data    = '{key: key_r, count: cval_r};
              res_ok_nxt = 1'b1;
            end else if (add_r && efound_r) begin
              ctl.wr_en  = 1'b1;
              wr_addr    = epos_r;
              wr_data    = '{key: key_r, count: cval_r};
              used_nxt   = used_r + UW'(1);
              res_ok_nxt = 1'b1;
            end
          end
          kct_pkg::MODE_LOOKUP: begin
            if (found_r) begin
              res_cnt_nxt = (fcount_r == '0) ? zdef_r : fcount_r;
              res_ok_nxt  = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      // move occupied slots down to the write pointer, in order; empty
      // slots keep their count unless a key moved out of them
      S_COMPACT: begin
        if (cnt_r < N_CNT) begin
          rd_addr  = cnt_r[AW-1:0];
          cnt_nxt  = cnt_r + (AW+1)'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r && rd_data.key != '0) begin
          ctl.wr_en = 1'b1;
          wr_addr   = wr_r[AW-1:0];
          wr_data   = rd_data;
          wr_nxt    = wr_r + (AW+1)'(1);
          moved_nxt[cnt_m1[AW-1:0]] = 1'b1;
        end
        if (cnt_r == N_CNT) state_nxt = S_CTAIL;
      end

      S_CTAIL: begin
        ctl.clr_tail = 1'b1;
        clr_from     = wr_r;
        state_nxt    = S_RESP;
      end

      S_RD_A: begin
        rd_addr   = sa_r;
        state_nxt = S_GOT_A;
      end

      S_GOT_A: begin
        state_nxt = S_RESP;
        case (mode_r)
          kct_pkg::MODE_READ: begin
            res_key_nxt = rd_data.key;
            res_cnt_nxt = rd_data.count;
            res_ok_nxt  = 1'b1;
          end
          kct_pkg::MODE_SETIDX: begin
            ctl.wr_en  = 1'b1;
            wr_addr    = sa_r;
            wr_data    = '{key: rd_data.key, count: cval_r};
            res_ok_nxt = 1'b1;
          end
          kct_pkg::MODE_DEL: begin
            if (rd_data.key != '0) used_nxt = used_r - UW'(1);
            cnt_nxt    = (AW+1)'(sa_r) + (AW+1)'(1);
            pend_nxt   = 1'b0;
            res_ok_nxt = 1'b1;
            state_nxt  = S_SHIFT;
          end
          kct_pkg::MODE_SWAP: begin
            hold_nxt  = rd_data;
            rd_addr   = sb_r;
            state_nxt = S_SWAP_B;
          end
          default: begin
          end
        endcase
      end

      S_SWAP_B: begin
        ctl.wr_en = 1'b1;
        wr_addr   = sb_r;
        wr_data   = hold_r;
        hold_nxt  = rd_data;
        state_nxt = S_SWAP_W;
      end

      S_SWAP_W: begin
        ctl.wr_en  = 1'b1;
        wr_addr    = sa_r;
        wr_data    = hold_r;
        res_ok_nxt = 1'b1;
        state_nxt  = S_RESP;
      end

      // shift later slots down by one
      S_SHIFT: begin
        if (cnt_r < N_CNT) begin
          rd_addr  = cnt_r[AW-1:0];
          cnt_nxt  = cnt_r + (AW+1)'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          ctl.wr_en = 1'b1;
          wr_addr   = cnt_m2[AW-1:0];
          wr_data   = rd_data;
        end
        if (cnt_r == N_CNT) state_nxt = S_DEL_LAST;
      end

      S_DEL_LAST: begin
        ctl.wr_en = 1'b1;
        wr_addr   = AW'(ENTRIES - 1);
        wr_data   = '0;
        state_nxt = S_RESP;
      end

      // hold the result until the output register is free
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0, 9'(used_r), res_cnt_r, res_key_r, res_ok_r};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    key_r     <= key_nxt;
    cval_r    <= cval_nxt;
    zdef_r    <= zdef_nxt;
    add_r     <= add_nxt;
    rem_r     <= rem_nxt;
    sa_r      <= sa_nxt;
    sb_r      <= sb_nxt;
    cnt_r     <= cnt_nxt;
    wr_r      <= wr_nxt;
    found_r   <= found_nxt;
    efound_r  <= efound_nxt;
    fpos_r    <= fpos_nxt;
    epos_r    <= epos_nxt;
    fcount_r  <= fcount_nxt;
    hold_r    <= hold_nxt;
    moved_r   <= moved_nxt;
    res_ok_r  <= res_ok_nxt;
    res_key_r <= res_key_nxt;
    res_cnt_r <= res_cnt_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

// ----- hdl/kct_checker.sv -----
// Port-level checker for the keyed count table, bound to the top level.
// Depends on keyed_count_table_unit port layout only.
`timescale 1ns / 1ps
`default_nettype none
module kct_checker #(
  parameter int ENTRIES = 32
) (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire [87:0] in_tdata,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [63:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // the block works on one operation at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[57:49] <= 9'(ENTRIES))
    else $error("keys_in_use above table size");

  // a failed operation returns no key and no count
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[48:1] == '0)
    else $error("failed result carries data");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind keyed_count_table_unit kct_checker #(.ENTRIES(ENTRIES)) u_kct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ----- tb/keyed_count_table_unit_test.sv -----
// Testbench for keyed_count_table_unit: drives operations over the input
// stream, predicts each result with a local table model and checks it.
// Depends on kct_pkg and the keyed_count_table_unit RTL.
`timescale 1ns / 1ps
module keyed_count_table_unit_test;

  localparam int SLOTS = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [kct_pkg::SLOT_W-1:0]  slot_b;
    logic [kct_pkg::SLOT_W-1:0]  slot_a;
    logic                        remove_if_empty;
    logic                        add_if_absent;
    logic [kct_pkg::COUNT_W-1:0] zero_default;
    logic [kct_pkg::COUNT_W-1:0] count_value;
    logic [kct_pkg::KEY_W-1:0]   key;
    logic [kct_pkg::MODE_W-1:0]  mode;
  } table_op_t;

  typedef struct packed {
    logic [kct_pkg::USED_W-1:0]  keys_in_use;
    logic [kct_pkg::COUNT_W-1:0] count_out;
    logic [kct_pkg::KEY_W-1:0]   key_out;
    logic                        ok;
  } table_reply_t;

  // Local copy of the table; predicts one reply per accepted operation.
  class count_table_scoreboard;
    logic [kct_pkg::KEY_W-1:0]   keys[SLOTS];
    logic [kct_pkg::COUNT_W-1:0] counts[SLOTS];
    table_reply_t pending_replies[$];
    int mismatches;

    function int find_slot(logic [kct_pkg::KEY_W-1:0] k);
      for (int i = 0; i < SLOTS; i++)
        if (keys[i] == k) return i;
      return -1;
    endfunction

    function void reset_table();
      for (int i = 0; i < SLOTS; i++) begin
        keys[i] = '0;
        counts[i] = '0;
      end
    endfunction

    // Apply an accepted operation and queue the reply it must produce.
    function void note_op(table_op_t op);
      table_reply_t r;
      int pos, wr, used;
      logic [kct_pkg::KEY_W-1:0] tk;
      logic [kct_pkg::COUNT_W-1:0] tc;
      r = '0;
      if (op.mode >= kct_pkg::MODE_INC && op.mode <= kct_pkg::MODE_LOOKUP &&
          op.key == '0) begin
        // rejected: zero key, nothing changes
      end else begin
        case (op.mode)
          kct_pkg::MODE_CLEAR: begin
            reset_table();
            r.ok = 1'b1;
          end
          kct_pkg::MODE_INC: begin
            pos = find_slot(op.key);
            if (pos >= 0) begin
              if (counts[pos] != kct_pkg::COUNT_MAX) counts[pos]++;
              r.ok = 1'b1;
            end else if (!op.add_if_absent) begin
              r.ok = 1'b1;
            end else begin
              pos = find_slot('0);
              if (pos >= 0) begin
                keys[pos] = op.key;
                counts[pos] = kct_pkg::COUNT_W'(1);
                r.ok = 1'b1;
              end
            end
          end
          kct_pkg::MODE_DEC: begin
            pos = find_slot(op.key);
            if (pos >= 0) begin
              if (counts[pos] != 0) begin
                counts[pos]--;
                r.ok = 1'b1;
              end
              if (counts[pos] == 0 && op.remove_if_empty) begin
                keys[pos] = '0;
                wr = 0;
                for (int rd = 0; rd < SLOTS; rd++) begin
                  if (keys[rd] != '0) begin
                    tk = keys[rd];
                    tc = counts[rd];
                    keys[rd] = '0;
                    counts[rd] = '0;
                    keys[wr] = tk;
                    counts[wr] = tc;
                    wr++;
                  end
                end
              end
            end
          end
          kct_pkg::MODE_SETKEY: begin
            pos = find_slot(op.key);
            if (pos < 0 && op.add_if_absent) begin
              pos = find_slot('0);
              if (pos >= 0) keys[pos] = op.key;
            end
            if (pos >= 0) begin
              counts[pos] = op.count_value;
              r.ok = 1'b1;
            end
          end
          kct_pkg::MODE_LOOKUP: begin
            pos = find_slot(op.key);
            if (pos >= 0) begin
              r.count_out = (counts[pos] == 0) ? op.zero_default : counts[pos];
              r.ok = 1'b1;
            end
          end
          kct_pkg::MODE_READ: if (op.slot_a < SLOTS) begin
            r.key_out = keys[op.slot_a];
            r.count_out = counts[op.slot_a];
            r.ok = 1'b1;
          end
          kct_pkg::MODE_SETIDX: if (op.slot_a < SLOTS) begin
            counts[op.slot_a] = op.count_value;
            r.ok = 1'b1;
          end
          kct_pkg::MODE_SWAP: if (op.slot_a < SLOTS && op.slot_b < SLOTS) begin
            tk = keys[op.slot_b];
            tc = counts[op.slot_b];
            keys[op.slot_b] = keys[op.slot_a];
            counts[op.slot_b] = counts[op.slot_a];
            keys[op.slot_a] = tk;
            counts[op.slot_a] = tc;
            r.ok = 1'b1;
          end
          kct_pkg::MODE_DEL: if (op.slot_a < SLOTS) begin
            for (int i = op.slot_a; i + 1 < SLOTS; i++) begin
              keys[i] = keys[i+1];
              counts[i] = counts[i+1];
            end
            keys[SLOTS-1] = '0;
            counts[SLOTS-1] = '0;
            r.ok = 1'b1;
          end
          default: ;
        endcase
      end
      used = 0;
      for (int i = 0; i < SLOTS; i++)
        if (keys[i] != '0) used++;
      r.keys_in_use = kct_pkg::USED_W'(used);
      pending_replies.push_back(r);
    endfunction

    function void check_reply(table_reply_t got);
      table_reply_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reply %h", got);
        return;
      end
      want = pending_replies.pop_front();
      if (got.ok !== want.ok || got.key_out !== want.key_out ||
          got.count_out !== want.count_out || got.keys_in_use !== want.keys_in_use) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reply mismatch: ok %b/%b key %h/%h count %h/%h used %0d/%0d",
                   want.ok, got.ok, want.key_out, got.key_out, want.count_out,
                   got.count_out, want.keys_in_use, got.keys_in_use);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;    // mode, key, count_value, zero_default, add, remove, slot_a, slot_b
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;   // ok, key_out, count_out, keys_in_use

  int send_idle_pct;
  int recv_stall_pct;
  int idle_cycles;
  bit stim_done;
  count_table_scoreboard table_sb;

  keyed_count_table_unit #(.ENTRIES(SLOTS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: stall at the phase's rate, check each result transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) table_sb.check_reply(out_tdata[57:0]);
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: count cycles with no transfer on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("keyed_count_table_unit test failed");
        $finish;
      end
    end
  end

  // Key pool kept small so that hits, fills and removals are common.
  function logic [kct_pkg::KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return $urandom();
      default: return $urandom_range(40, 1);
    endcase
  endfunction

  // Idle if the phase asks for it, present one operation and hold it
  // until the transfer.
  task automatic send_op(table_op_t op);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    table_sb.note_op(op);
  endtask

  task automatic send_random_op();
    table_op_t op;
    int pick;
    op.key = pick_key();
    op.count_value = kct_pkg::COUNT_W'(($urandom_range(3) == 0) ? $urandom_range(65535)
                                                                : $urandom_range(3));
    op.zero_default = kct_pkg::COUNT_W'($urandom_range(65535));
    op.add_if_absent = ($urandom_range(3) != 0);
    op.remove_if_empty = 1'($urandom_range(1));
    op.slot_a = kct_pkg::SLOT_W'(($urandom_range(7) == 0) ? $urandom_range(255)
                                                          : $urandom_range(SLOTS - 1));
    op.slot_b = kct_pkg::SLOT_W'(($urandom_range(7) == 0) ? $urandom_range(255)
                                                          : $urandom_range(SLOTS - 1));
    pick = $urandom_range(99);
    if (pick < 1) op.mode = kct_pkg::MODE_CLEAR;
    else if (pick < 35) op.mode = kct_pkg::MODE_INC;
    else if (pick < 52) op.mode = kct_pkg::MODE_DEC;
    else if (pick < 60) op.mode = kct_pkg::MODE_SETKEY;
    else if (pick < 70) op.mode = kct_pkg::MODE_LOOKUP;
    else if (pick < 80) op.mode = kct_pkg::MODE_READ;
    else if (pick < 85) op.mode = kct_pkg::MODE_SETIDX;
    else if (pick < 91) op.mode = kct_pkg::MODE_SWAP;
    else if (pick < 96) op.mode = kct_pkg::MODE_DEL;
    else op.mode = kct_pkg::MODE_W'($urandom_range(15, 9));
    send_op(op);
  endtask

  function table_op_t make_op(logic [kct_pkg::MODE_W-1:0] m, logic [kct_pkg::KEY_W-1:0] k,
                              logic [kct_pkg::COUNT_W-1:0] c, logic add, logic rem,
                              logic [kct_pkg::SLOT_W-1:0] a, logic [kct_pkg::SLOT_W-1:0] b);
    table_op_t op;
    op.mode = m; op.key = k; op.count_value = c; op.zero_default = 16'hBEEF;
    op.add_if_absent = add; op.remove_if_empty = rem; op.slot_a = a; op.slot_b = b;
    return op;
  endfunction

  initial begin
    table_sb = new();
    table_sb.reset_table();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    idle_cycles = 0;
    stim_done = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: rejects, saturation, zero-count decrement, lookup default,
    // range errors, empty slot read, delete shifting, unused mode.
    send_op(make_op(kct_pkg::MODE_INC, '0, 0, 1, 0, 0, 0));
    send_op(make_op(kct_pkg::MODE_INC, 32'h1234, 0, 0, 0, 0, 0));
    send_op(make_op(kct_pkg::MODE_INC, 32'hFFFFFFFF, 0, 1, 0, 0, 0));
    send_op(make_op(kct_pkg::MODE_SETKEY, 32'hFFFFFFFF, 16'hFFFF, 0, 0, 0, 0));
    send_op(make_op(kct_pkg::MODE_INC, 32'hFFFFFFFF, 0, 1, 0, 0, 0));
    send_op(make_op(kct_pkg::MODE_SETKEY, 32'h0000_0001, 16'h0000, 1, 0, 0, 0));
    send_op(make_op(kct_pkg::MODE_LOOKUP, 32'h0000_0001, 0, 0, 0, 0, 0));
    send_op(make_op(kct_pkg::MODE_LOOKUP, 32'h5555_AAAA, 0, 0, 0, 0, 0));
    send_op(make_op(kct_pkg::MODE_DEC, 32'h0000_0001, 0, 0, 1, 0, 0));
    send_op(make_op(kct_pkg::MODE_DEC, 32'h7777, 0, 0, 0, 0, 0));
    send_op(make_op(kct_pkg::MODE_READ, '0, 0, 0, 0, 8'd0, 0));
    send_op(make_op(kct_pkg::MODE_READ, '0, 0, 0, 0, 8'd31, 0));
    send_op(make_op(kct_pkg::MODE_READ, '0, 0, 0, 0, 8'd255, 0));
    send_op(make_op(kct_pkg::MODE_SETIDX, '0, 16'hA5A5, 0, 0, 8'd31, 0));
    send_op(make_op(kct_pkg::MODE_SETIDX, '0, 16'h5A5A, 0, 0, 8'd32, 0));
    send_op(make_op(kct_pkg::MODE_SWAP, '0, 0, 0, 0, 8'd0, 8'd31));
    send_op(make_op(kct_pkg::MODE_SWAP, '0, 0, 0, 0, 8'd0, 8'd255));
    send_op(make_op(kct_pkg::MODE_DEL, '0, 0, 0, 0, 8'd0, 0));
    send_op(make_op(kct_pkg::MODE_DEL, '0, 0, 0, 0, 8'd200, 0));
    send_op(make_op(4'd15, 32'h1, 0, 1, 1, 0, 0));
    // Fill the table to hit the full case, then clear.
    for (int i = 1; i <= SLOTS + 1; i++)
      send_op(make_op(kct_pkg::MODE_INC, 32'h8000_0000 | i, 0, 1, 0, 0, 0));
    send_op(make_op(kct_pkg::MODE_SETKEY, 32'h4242_4242, 16'h1, 1, 0, 0, 0));
    send_op(make_op(kct_pkg::MODE_CLEAR, '0, 0, 0, 0, 0, 0));

    // Random phases: no idling, sender idle, receiver stall, both light.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      for (int n = 0; n < 265; n++) send_random_op();
    end
    in_tvalid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;

    while (table_sb.pending_replies.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (table_sb.mismatches == 0 && table_sb.pending_replies.size() == 0)
      $display("keyed_count_table_unit test passed");
    else
      $display("keyed_count_table_unit test failed");
    $finish;
  end
endmodule

// ----- keyed_count_table_unit.f -----
hdl/kct_pkg.sv
hdl/kct_store.sv
hdl/keyed_count_table_unit.sv
hdl/kct_checker.sv
tb/keyed_count_table_unit_test.sv
